// File: design/aslc_pkg.sv
// Shared types, widths, codes and the length scaling function of the
// adaptive step length controller. No dependencies.
package aslc_pkg;

    localparam int LEN_W      = 32;
    localparam int VAL_W      = 48;
    localparam int FAC_W      = 16;
    localparam int EPS_W      = 47;
    localparam int STREAK_W   = 9;
    localparam int ITER_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 144;
    localparam int CMP_W      = VAL_W + 2;
    localparam int PROD_W     = LEN_W + FAC_W + 1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [1:0] RANGE_LOOSE        = 2'd0;
    localparam logic [1:0] RANGE_STRICT_STEP  = 2'd1;
    localparam logic [1:0] RANGE_STRICT_TOTAL = 2'd2;
    localparam logic [1:0] RANGE_RESERVED     = 2'd3;

    localparam logic signed [STREAK_W-1:0] STREAK_NONE = -9'sd1;
    localparam logic signed [STREAK_W-1:0] STREAK_MAX  = 9'sd255;

    localparam logic [LEN_W-1:0]    RST_MIN_LENGTH  = 32'd0;
    localparam logic [LEN_W-1:0]    RST_MAX_LENGTH  = 32'd65536;
    localparam logic [FAC_W-1:0]    RST_RISE_FACTOR = 16'd4506;
    localparam logic [FAC_W-1:0]    RST_DROP_FACTOR = 16'd2048;
    localparam logic [EPS_W-1:0]    RST_EPSILON     = '0;
    localparam logic [LEN_W-1:0]    RST_CHANGE_THR  = '0;
    localparam logic [ITER_W-1:0]   RST_MAX_ITER    = 16'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LENGTH     = 3'd0,
        REG_MAX_LENGTH     = 3'd1,
        REG_RISE_FACTOR    = 3'd2,
        REG_DROP_FACTOR    = 3'd3,
        REG_EPSILON        = 3'd4,
        REG_CHANGE_THR     = 3'd5,
        REG_MAX_REJ_STREAK = 3'd6,
        REG_MAX_ITER       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0]           len_floor;
        logic [LEN_W-1:0]           len_ceil;
        logic [FAC_W-1:0]           rise_factor;
        logic [FAC_W-1:0]           drop_factor;
        logic [EPS_W-1:0]           epsilon;
        logic [LEN_W-1:0]           change_threshold;
        logic signed [STREAK_W-1:0] max_rejected_streak;
        logic [ITER_W-1:0]          max_iterations;
    } cfg_t;

    typedef struct packed {
        logic                    op;
        logic signed [VAL_W-1:0] objective_value;
        logic [LEN_W-1:0]        change;
        logic [LEN_W-1:0]        previous_length;
        logic                    reuse_previous;
        logic                    descent;
        logic [1:0]              range_mode;
    } item_t;

    typedef struct packed {
        logic active;
        logic descent;
        logic strict;
        logic total;
    } flags_t;

    typedef struct packed {
        logic [LEN_W-1:0]           step_length;
        logic [LEN_W-1:0]           accepted_total;
        logic signed [VAL_W-1:0]    accepted_value;
        logic signed [STREAK_W-1:0] reject_streak;
        logic [ITER_W-1:0]          iteration_count;
        flags_t                     flags;
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]        retreat_length;
        logic [LEN_W-1:0]        advance_length;
        logic                    finished;
        logic signed [VAL_W-1:0] best_value;
        logic [LEN_W-1:0]        total_length;
    } result_t;

    // (len * factor + half) >> 12, saturated to 32 bits
    function automatic logic [LEN_W-1:0] scale_len(input logic [LEN_W-1:0] len,
                                                  input logic [FAC_W-1:0] factor);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-13:0] shifted;
        prod = PROD_W'(len) * PROD_W'(factor) + PROD_W'(2048);
        shifted = prod[PROD_W-1:12];
        if (shifted[PROD_W-13:LEN_W] != '0) begin
            return '1;
        end
        return shifted[LEN_W-1:0];
    endfunction

endpackage

// File: design/adaptive_step_length_controller.sv
// Adaptive step length controller: input register, one pass of step logic,
// result register. Depends on aslc_pkg and aslc_eval.
// Throughput: one item per cycle while the result register is not stalled;
// the search state updates as the result registers.
// Reset (aresetn low, synchronous): registers back to defaults, search idle,
// both pipeline stages empty. Config writes are always ready.
module adaptive_step_length_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // objective_value, change, previous_length, reuse_previous, descent,
    // range_mode, zero pad
    input  logic [aslc_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // retreat_length, advance_length, best_value, total_length
    output logic [aslc_pkg::M_TDATA_W-1:0]   m_tdata,
    // finished
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aslc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aslc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aslc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    item_t   item_in;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    fire;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;

    assign item_in.op              = s_tuser;
    assign item_in.objective_value = $signed(s_tdata[47:0]);
    assign item_in.change          = s_tdata[79:48];
    assign item_in.previous_length = s_tdata[111:80];
    assign item_in.reuse_previous  = s_tdata[112];
    assign item_in.descent         = s_tdata[113];
    assign item_in.range_mode      = s_tdata[115:114];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.len_floor           <= RST_MIN_LENGTH;
            cfg_reg.len_ceil            <= RST_MAX_LENGTH;
            cfg_reg.rise_factor         <= RST_RISE_FACTOR;
            cfg_reg.drop_factor         <= RST_DROP_FACTOR;
            cfg_reg.epsilon             <= RST_EPSILON;
            cfg_reg.change_threshold    <= RST_CHANGE_THR;
            cfg_reg.max_rejected_streak <= STREAK_NONE;
            cfg_reg.max_iterations      <= RST_MAX_ITER;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_MIN_LENGTH:     cfg_reg.len_floor   <= cfg_data[LEN_W-1:0];
                REG_MAX_LENGTH:     cfg_reg.len_ceil    <= cfg_data[LEN_W-1:0];
                REG_RISE_FACTOR:    cfg_reg.rise_factor <= cfg_data[FAC_W-1:0];
                REG_DROP_FACTOR:    cfg_reg.drop_factor <= cfg_data[FAC_W-1:0];
                REG_EPSILON:        cfg_reg.epsilon     <= cfg_data[EPS_W-1:0];
                REG_CHANGE_THR:     cfg_reg.change_threshold <= cfg_data[LEN_W-1:0];
                REG_MAX_REJ_STREAK: cfg_reg.max_rejected_streak <=
                                        $signed(cfg_data[STREAK_W-1:0]);
                REG_MAX_ITER:       cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
            endcase
        end
    end

    aslc_eval u_eval (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.step_length     <= '0;
            state_reg.accepted_total  <= '0;
            state_reg.accepted_value  <= '0;
            state_reg.reject_streak   <= STREAK_NONE;
            state_reg.iteration_count <= '0;
            state_reg.flags           <= '0;
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.finished;
    assign m_tdata  = {out_reg.total_length, out_reg.best_value,
                       out_reg.advance_length, out_reg.retreat_length};

endmodule

// File: design/aslc_eval.sv
// Next-state and result logic for one item of the step length controller.
// Depends on aslc_pkg.
module aslc_eval (
    input  aslc_pkg::cfg_t    cfg,
    input  aslc_pkg::state_t  state,
    input  aslc_pkg::item_t   item,
    output aslc_pkg::state_t  state_next,
    output aslc_pkg::result_t result
);
    import aslc_pkg::*;

    logic [LEN_W-1:0]        rise_len;
    logic [LEN_W-1:0]        drop_len;
    logic [LEN_W:0]          total_sum;
    logic [LEN_W-1:0]        total_sat;
    logic signed [CMP_W-1:0] val_x;
    logic signed [CMP_W-1:0] acc_x;
    logic signed [CMP_W-1:0] eps_x;
    logic                    better;
    logic [ITER_W-1:0]       iter_inc;
    logic                    start_strict;
    logic [LEN_W-1:0]        start_len;
    logic [LEN_W-1:0]        alpha;
    logic [LEN_W-1:0]        retreat;
    logic                    done;

    assign rise_len  = scale_len(state.step_length, cfg.rise_factor);
    assign drop_len  = scale_len(state.step_length, cfg.drop_factor);
    assign total_sum = {1'b0, state.accepted_total} + {1'b0, state.step_length};
    assign total_sat = total_sum[LEN_W] ? '1 : total_sum[LEN_W-1:0];
    assign val_x     = CMP_W'(item.objective_value);
    assign acc_x     = CMP_W'(state.accepted_value);
    assign eps_x     = $signed({{(CMP_W-EPS_W){1'b0}}, cfg.epsilon});
    assign better    = state.flags.descent ? (val_x < acc_x - eps_x)
                                           : (val_x > acc_x + eps_x);
    assign iter_inc  = (state.iteration_count != '1) ? state.iteration_count + 1'b1
                                                     : state.iteration_count;
    assign start_strict = (item.range_mode != RANGE_LOOSE) ||
                          (cfg.len_floor == cfg.len_ceil);

    always_comb begin
        start_len = (item.reuse_previous && item.previous_length != '0)
                    ? item.previous_length : cfg.len_ceil;
        if (start_strict) begin
            if (start_len > cfg.len_ceil) begin
                start_len = cfg.len_ceil;
            end else if (start_len < cfg.len_floor) begin
                start_len = cfg.len_floor;
            end
        end
    end

    always_comb begin
        state_next = state;
        result     = '0;
        alpha      = state.step_length;
        retreat    = '0;
        done       = 1'b0;
        if (item.op == OP_START) begin
            state_next.accepted_total  = '0;
            state_next.accepted_value  = item.objective_value;
            state_next.reject_streak   = STREAK_NONE;
            state_next.iteration_count = '0;
            state_next.step_length     = start_len;
            if (cfg.max_iterations == '0) begin
                state_next.flags = '0;
                result.finished  = 1'b1;
            end else begin
                state_next.flags.active  = 1'b1;
                state_next.flags.descent = item.descent;
                state_next.flags.strict  = start_strict;
                state_next.flags.total   = (item.range_mode == RANGE_STRICT_TOTAL);
                result.advance_length    = start_len;
            end
        end else if (!state.flags.active) begin
            result.finished = 1'b1;
        end else begin
            state_next.iteration_count = iter_inc;
            if (item.change <= cfg.change_threshold) begin
                retreat = alpha;
                done    = 1'b1;
            end else if (better) begin
                state_next.accepted_value = item.objective_value;
                state_next.accepted_total = total_sat;
                if (state.flags.strict || alpha < cfg.len_ceil) begin
                    alpha = (rise_len > cfg.len_ceil) ? cfg.len_ceil : rise_len;
                    if (state.flags.total &&
                        ({1'b0, total_sat} + {1'b0, alpha}) > {1'b0, cfg.len_ceil}) begin
                        if (total_sat >= cfg.len_ceil) begin
                            alpha = '0;
                            done  = 1'b1;
                        end else begin
                            alpha = cfg.len_ceil - total_sat;
                        end
                    end
                end
                state_next.reject_streak = '0;
            end else begin
                retreat = alpha;
                if (state.reject_streak != STREAK_NONE) begin
                    if (!cfg.max_rejected_streak[STREAK_W-1] &&
                        state.reject_streak >= cfg.max_rejected_streak) begin
                        done = 1'b1;
                    end
                    if (state.reject_streak < STREAK_MAX) begin
                        state_next.reject_streak = state.reject_streak + 9'sd1;
                    end
                end
                if (!done) begin
                    if (alpha == cfg.len_floor) begin
                        done = 1'b1;
                    end else if (alpha > cfg.len_ceil) begin
                        alpha = cfg.len_ceil;
                    end else begin
                        alpha = (drop_len < cfg.len_floor) ? cfg.len_floor : drop_len;
                    end
                end
            end
            if (!done && iter_inc >= cfg.max_iterations) begin
                done = 1'b1;
            end
            state_next.step_length = alpha;
            result.retreat_length  = retreat;
            if (done) begin
                state_next.flags = '0;
                result.finished  = 1'b1;
            end else begin
                result.advance_length = alpha;
            end
        end
        result.best_value   = state_next.accepted_value;
        result.total_length = state_next.accepted_total;
    end

endmodule

// File: design/aslc_checker.sv
// Port-level checks for the adaptive step length controller, bound to the
// top level. Depends on aslc_pkg.
module aslc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [aslc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import aslc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a finished search never asks for another step
    a_done_no_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[63:32] == '0)
        else $error("advance length nonzero on finished beat");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind adaptive_step_length_controller aslc_checker u_aslc_checker (.*);

// File: test/tb_adaptive_step_length_controller.sv
// Self-checking testbench for adaptive_step_length_controller: directed and random line
// searches, with register writes between phases and random stalls on both streams.
// Depends on aslc_pkg and the controller RTL; results are checked against an internal predictor.
module tb_adaptive_step_length_controller;
    import aslc_pkg::*;

    localparam int SETTLE_CYC = 4;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 42;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_e;

    typedef struct packed {
        act_kind_e             kind;
        item_t                 item;
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] data;
    } action_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    action_t beat_plan[$];
    result_t expected_answers[$];
    logic    stim_done = 1'b0;
    int      err_count = 0;
    int      n_starts  = 0;
    int      n_evals   = 0;
    int      n_writes  = 0;
    int      n_checked = 0;
    int      n_ended   = 0;

    // predictor copy of registers and search state
    cfg_t              cfg_m;
    logic [LEN_W-1:0]  st_len;
    logic [LEN_W-1:0]  st_total;
    logic [VAL_W-1:0]  st_best;
    int                st_streak;
    int                st_iter;
    logic              st_active;
    logic              st_desc;
    logic              st_strict;
    logic              st_tot;

    adaptive_step_length_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("tb_adaptive_step_length_controller NOT OK");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [LEN_W-1:0] scaled_length(input logic [LEN_W-1:0] len,
                                                       input logic [FAC_W-1:0] f);
        logic [47:0] p;
        p = ({16'b0, len} * {32'b0, f} + 48'd2048) >> 12;
        if (p[47:32] != 0) begin
            return '1;
        end
        return p[31:0];
    endfunction

    function automatic result_t answer(input logic [LEN_W-1:0] retreat,
                                       input logic [LEN_W-1:0] advance, input logic fin);
        result_t r;
        r.retreat_length = retreat;
        r.advance_length = advance;
        r.finished       = fin;
        r.best_value     = st_best;
        r.total_length   = st_total;
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MIN_LENGTH:     cfg_m.len_floor           = d[LEN_W-1:0];
            REG_MAX_LENGTH:     cfg_m.len_ceil            = d[LEN_W-1:0];
            REG_RISE_FACTOR:    cfg_m.rise_factor         = d[FAC_W-1:0];
            REG_DROP_FACTOR:    cfg_m.drop_factor         = d[FAC_W-1:0];
            REG_EPSILON:        cfg_m.epsilon             = d[EPS_W-1:0];
            REG_CHANGE_THR:     cfg_m.change_threshold    = d[LEN_W-1:0];
            REG_MAX_REJ_STREAK: cfg_m.max_rejected_streak = d[STREAK_W-1:0];
            REG_MAX_ITER:       cfg_m.max_iterations      = d[ITER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic next_step_answer(input item_t it, output result_t r);
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] retreat;
        logic [LEN_W:0]   sum;
        longint           val;
        longint           best;
        longint           eps;
        longint           lim;
        logic             done;
        logic             better;
        val = {{16{it.objective_value[VAL_W-1]}}, it.objective_value};
        if (it.op == OP_START) begin
            st_strict = (it.range_mode != RANGE_LOOSE) ||
                        (cfg_m.len_floor == cfg_m.len_ceil);
            st_tot    = (it.range_mode == RANGE_STRICT_TOTAL);
            st_desc   = it.descent;
            len = cfg_m.len_ceil;
            if (it.reuse_previous && it.previous_length != 0) begin
                len = it.previous_length;
            end
            if (st_strict) begin
                if (len > cfg_m.len_ceil) begin
                    len = cfg_m.len_ceil;
                end else if (len < cfg_m.len_floor) begin
                    len = cfg_m.len_floor;
                end
            end
            st_total  = '0;
            st_best   = it.objective_value;
            st_streak = -1;
            st_iter   = 0;
            st_len    = len;
            st_active = (cfg_m.max_iterations != 0);
            r = st_active ? answer('0, len, 1'b0) : answer('0, '0, 1'b1);
        end else if (!st_active) begin
            r = answer('0, '0, 1'b1);
        end else begin
            len     = st_len;
            retreat = '0;
            done    = 1'b0;
            if (st_iter < 65535) st_iter++;
            if (it.change <= cfg_m.change_threshold) begin
                retreat = len;
                done    = 1'b1;
            end else begin
                best   = {{16{st_best[VAL_W-1]}}, st_best};
                eps    = {17'b0, cfg_m.epsilon};
                better = st_desc ? (val < best - eps) : (val > best + eps);
                if (better) begin
                    sum      = {1'b0, st_total} + {1'b0, len};
                    st_best  = it.objective_value;
                    st_total = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
                    if (st_strict || len < cfg_m.len_ceil) begin
                        len = scaled_length(len, cfg_m.rise_factor);
                        if (len > cfg_m.len_ceil) len = cfg_m.len_ceil;
                        if (st_tot && ({1'b0, st_total} + {1'b0, len}) >
                                      {1'b0, cfg_m.len_ceil}) begin
                            if (st_total >= cfg_m.len_ceil) begin
                                len  = '0;
                                done = 1'b1;
                            end else begin
                                len = cfg_m.len_ceil - st_total;
                            end
                        end
                    end
                    st_streak = 0;
                end else begin
                    lim = {{55{cfg_m.max_rejected_streak[STREAK_W-1]}},
                           cfg_m.max_rejected_streak};
                    retreat = len;
                    if (st_streak != -1) begin
                        if (lim >= 0 && st_streak >= lim) done = 1'b1;
                        if (st_streak < 255) st_streak++;
                    end
                    if (!done) begin
                        if (len == cfg_m.len_floor) begin
                            done = 1'b1;
                        end else if (len > cfg_m.len_ceil) begin
                            len = cfg_m.len_ceil;
                        end else begin
                            len = scaled_length(len, cfg_m.drop_factor);
                            if (len < cfg_m.len_floor) len = cfg_m.len_floor;
                        end
                    end
                end
            end
            if (!done && st_iter >= cfg_m.max_iterations) done = 1'b1;
            st_len = len;
            if (done) begin
                st_active = 1'b0;
                r = answer(retreat, '0, 1'b1);
            end else begin
                r = answer(retreat, len, 1'b0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    // ---------------- stimulus plan ----------------
    task automatic push_item(input logic op, input logic [VAL_W-1:0] val,
                             input logic [LEN_W-1:0] chg, input logic [LEN_W-1:0] prev,
                             input logic reuse, input logic desc, input logic [1:0] mode);
        action_t a;
        a = '0;
        a.kind                 = ACT_ITEM;
        a.item.op              = op;
        a.item.objective_value = val;
        a.item.change          = chg;
        a.item.previous_length = prev;
        a.item.reuse_previous  = reuse;
        a.item.descent         = desc;
        a.item.range_mode      = mode;
        beat_plan.push_back(a);
    endtask

    task automatic push_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        action_t a;
        a = '0;
        a.kind = ACT_CFG;
        a.idx  = idx;
        a.data = d;
        beat_plan.push_back(a);
    endtask

    task automatic push_drain();
        action_t a;
        a = '0;
        a.kind = ACT_DRAIN;
        beat_plan.push_back(a);
    endtask

    task automatic push_config(input logic [31:0] mn, input logic [31:0] mx,
                               input logic [15:0] rise, input logic [15:0] drop,
                               input logic [46:0] eps, input logic [31:0] thr,
                               input logic [8:0] streak, input logic [15:0] iter);
        push_drain();
        push_reg(REG_MIN_LENGTH, 47'(mn));
        push_reg(REG_MAX_LENGTH, 47'(mx));
        push_reg(REG_RISE_FACTOR, 47'(rise));
        push_reg(REG_DROP_FACTOR, 47'(drop));
        push_reg(REG_EPSILON, eps);
        push_reg(REG_CHANGE_THR, 47'(thr));
        push_reg(REG_MAX_REJ_STREAK, 47'(streak));
        push_reg(REG_MAX_ITER, 47'(iter));
    endtask

    function automatic logic [31:0] change_above(input logic [31:0] thr);
        logic [31:0] span;
        span = 32'hFFFF_FFFF - thr;
        if (span == 0) return $urandom;
        return thr + 32'd1 + ($urandom % span);
    endfunction

    initial begin : plan_p
        logic [31:0] g_min, g_max, g_thr, prev;
        logic [15:0] g_rise, g_drop, g_iter;
        logic [46:0] g_eps;
        logic [8:0]  g_streak;
        logic [63:0] r64;
        logic [47:0] best, delta, v;
        logic        desc, improve;
        logic [1:0]  mode;
        int          ph, n, k;

        // reset settings
        push_item(OP_EVAL, 48'h1234, 32'h10, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_START, 48'h7FFF_FFFF_FFFF, '0, '0, 1'b0, 1'b1, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h0000_0001_0000, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h0000_0002_0000, 32'h1, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h0000_0000_8000, 32'h100, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h0, 32'h0, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_START, 48'h8000_0000_0000, '0, 32'hFFFF_FFFF, 1'b1, 1'b0,
                  RANGE_STRICT_STEP);
        push_item(OP_EVAL, 48'h8000_0000_0001, 32'h5, '0, 1'b0, 1'b0, RANGE_LOOSE);
        // restart while active, strict total
        push_item(OP_START, 48'h0, '0, 32'h8000, 1'b1, 1'b0, RANGE_STRICT_TOTAL);
        push_item(OP_EVAL, 48'h1_0000, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h2_0000, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h3_0000, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_START, 48'h0, '0, '0, 1'b0, 1'b1, RANGE_RESERVED);
        push_item(OP_EVAL, 48'h0, 32'h7, '0, 1'b0, 1'b0, RANGE_LOOSE);
        // no iterations allowed
        push_config(32'd0, 32'd65536, 16'd4506, 16'd2048, '0, '0, 9'h1FF, 16'd0);
        push_item(OP_START, 48'h5, '0, '0, 1'b0, 1'b1, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h1, 32'h9, '0, 1'b0, 1'b1, RANGE_LOOSE);
        // top-end lengths, saturating scale and total
        push_config('1, '1, 16'hFFFF, 16'd1, '0, '0, 9'd255, 16'hFFFF);
        push_item(OP_START, 48'h0, '0, '0, 1'b0, 1'b1, RANGE_LOOSE);
        push_item(OP_EVAL, 48'hFFFF_FFFF_FFFF, 32'hFFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h8000_0000_0000, 32'hFFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h8000_0000_0000, 32'hFFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        // largest threshold and epsilon, single iteration
        push_config('0, '1, 16'd1, 16'hFFFF, '1, '1, 9'd0, 16'd1);
        push_item(OP_START, 48'h8000_0000_0000, '0, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, RANGE_LOOSE);
        // zero streak limit: accept then reject
        push_config('0, '1, 16'd4506, 16'd2048, '1, '0, 9'd0, 16'd3);
        push_item(OP_START, 48'h8000_0000_0000, '0, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h7FFF_FFFF_FFFF, 32'h1, '0, 1'b0, 1'b0, RANGE_LOOSE);
        push_item(OP_EVAL, 48'h0, 32'h1, '0, 1'b0, 1'b0, RANGE_LOOSE);

        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: begin g_min = 32'd0; g_max = 32'h1_0000; end
                1: begin
                    g_min = $urandom_range(1, 'h4000);
                    g_max = g_min + $urandom_range(0, 'h4_0000);
                end
                2: begin g_min = $urandom; g_max = $urandom; end
                default: begin g_min = $urandom_range(0, 'h100); g_max = '1; end
            endcase
            g_rise = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(4097, 8192));
            g_drop = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1, 4095));
            r64 = {$urandom, $urandom};
            case ($urandom_range(0, 2))
                0: g_eps = '0;
                1: g_eps = 47'($urandom_range(0, 'hFFFF));
                default: g_eps = r64[46:0];
            endcase
            case ($urandom_range(0, 5))
                0, 1: g_thr = '0;
                2, 3: g_thr = $urandom_range(0, 'hFFFF);
                4: g_thr = $urandom;
                default: g_thr = '1;
            endcase
            case ($urandom_range(0, 3))
                0: g_streak = 9'h1FF;
                1: g_streak = 9'($urandom_range(0, 4));
                2: g_streak = 9'd255;
                default: g_streak = 9'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: g_iter = 16'hFFFF;
                1: g_iter = 16'd1;
                default: g_iter = 16'($urandom_range(2, 30));
            endcase
            push_config(g_min, g_max, g_rise, g_drop, g_eps, g_thr, g_streak, g_iter);

            n = 0;
            while (n < PHASE_LEN) begin
                if ($urandom_range(0, 9) == 0) begin
                    r64 = {$urandom, $urandom};
                    push_item(1'($urandom_range(0, 1)), r64[47:0], $urandom, $urandom,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              2'($urandom_range(0, 3)));
                    n++;
                end else begin
                    desc = 1'($urandom_range(0, 1));
                    r64  = {$urandom, $urandom};
                    best = r64[47:0];
                    mode = ($urandom_range(0, 15) == 0) ? RANGE_RESERVED
                                                         : 2'($urandom_range(0, 2));
                    case ($urandom_range(0, 3))
                        0: prev = '0;
                        1: prev = $urandom;
                        default: prev = g_min + $urandom_range(0, 'h2_0000);
                    endcase
                    push_item(OP_START, best, $urandom, prev, 1'($urandom_range(0, 1)),
                              desc, mode);
                    k = $urandom_range(1, 24);
                    n += k + 1;
                    repeat (k) begin
                        improve = ($urandom_range(0, 2) != 0);
                        if (improve) begin
                            delta = {1'b0, g_eps} + 48'd1 + 48'($urandom_range(0, 'hF_FFFF));
                            best  = desc ? best - delta : best + delta;
                            v     = best;
                        end else begin
                            delta = 48'($urandom_range(0, 'hF_FFFF));
                            v     = desc ? best + delta : best - delta;
                        end
                        push_item(OP_EVAL, v,
                                  ($urandom_range(0, 19) == 0) ? $urandom_range(0, g_thr)
                                                               : change_above(g_thr),
                                  $urandom, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    end
                end
            end
        end
        push_drain();
    end

    // ---------------- stream and register driver ----------------
    always @(posedge aclk) begin : drive_p
        logic    nv_s, nv_c;
        action_t act;
        int      in_flight, settle, gap_left, burst_left;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            cfg_valid  <= 1'b0;
            stim_done  <= 1'b0;
            in_flight  = 0;
            settle     = 0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            in_flight = in_flight + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
            nv_s = s_tvalid && !s_tready;
            nv_c = cfg_valid && !cfg_ready;
            if (!nv_s && !nv_c) begin
                if (beat_plan.size() == 0) begin
                    stim_done <= 1'b1;
                end else if (beat_plan[0].kind == ACT_DRAIN) begin
                    if (in_flight != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYC) begin
                        settle++;
                    end else begin
                        settle = 0;
                        void'(beat_plan.pop_front());
                    end
                end else if (beat_plan[0].kind == ACT_CFG) begin
                    act = beat_plan.pop_front();
                    nv_c = 1'b1;
                    cfg_index <= act.idx;
                    cfg_data  <= act.data;
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    act = beat_plan.pop_front();
                    nv_s = 1'b1;
                    s_tdata <= {4'b0, act.item.range_mode, act.item.descent,
                                act.item.reuse_previous, act.item.previous_length,
                                act.item.change, act.item.objective_value};
                    s_tuser <= act.item.op;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_tvalid  <= nv_s;
            cfg_valid <= nv_c;
        end
    end

    // ---------------- result receiver ----------------
    always @(posedge aclk) begin : recv_p
        int rx_seen, hold_left, mode_left, rx_mode;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_seen   = 0;
            hold_left = 0;
            mode_left = 0;
            rx_mode   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                rx_seen++;
                if (rx_seen % 200 == 100) hold_left = 120;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------- prediction and checking ----------------
    always @(posedge aclk) begin : check_p
        item_t   it;
        result_t want, got;
        if (!aresetn) begin
            cfg_m.len_floor           = RST_MIN_LENGTH;
            cfg_m.len_ceil            = RST_MAX_LENGTH;
            cfg_m.rise_factor         = RST_RISE_FACTOR;
            cfg_m.drop_factor         = RST_DROP_FACTOR;
            cfg_m.epsilon             = RST_EPSILON;
            cfg_m.change_threshold    = RST_CHANGE_THR;
            cfg_m.max_rejected_streak = STREAK_NONE;
            cfg_m.max_iterations      = RST_MAX_ITER;
            st_len    = '0;
            st_total  = '0;
            st_best   = '0;
            st_streak = -1;
            st_iter   = 0;
            st_active = 1'b0;
            st_desc   = 1'b0;
            st_strict = 1'b0;
            st_tot    = 1'b0;
            expected_answers.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                write_reg(cfg_index_t'(cfg_index), cfg_data);
                n_writes++;
            end
            if (s_tvalid && s_tready) begin
                it.op              = s_tuser;
                it.objective_value = s_tdata[47:0];
                it.change          = s_tdata[79:48];
                it.previous_length = s_tdata[111:80];
                it.reuse_previous  = s_tdata[112];
                it.descent         = s_tdata[113];
                it.range_mode      = s_tdata[115:114];
                if (it.op == OP_START) n_starts++;
                else n_evals++;
                next_step_answer(it, want);
                expected_answers.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.retreat_length = m_tdata[31:0];
                got.advance_length = m_tdata[63:32];
                got.best_value     = m_tdata[111:64];
                got.total_length   = m_tdata[143:112];
                got.finished       = m_tlast;
                if (expected_answers.size() == 0) begin
                    $error("result beat with no item pending");
                    err_count++;
                end else begin
                    want = expected_answers.pop_front();
                    check_field("retreat_length", 64'(want.retreat_length),
                                64'(got.retreat_length));
                    check_field("advance_length", 64'(want.advance_length),
                                64'(got.advance_length));
                    check_field("finished", 64'(want.finished), 64'(got.finished));
                    check_field("best_value", 64'(want.best_value), 64'(got.best_value));
                    check_field("total_length", 64'(want.total_length),
                                64'(got.total_length));
                    n_checked++;
                    if (want.finished) n_ended++;
                end
            end
        end
    end

    // ---------------- reset and end of run ----------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (expected_answers.size() != 0) begin
            $error("%0d results never arrived", expected_answers.size());
            err_count++;
        end
        $display("Sent %0d starts and %0d evaluations across %0d register writes;",
                 n_starts, n_evals, n_writes);
        $display("checked %0d results, %0d of them ending a search.", n_checked, n_ended);
        if (err_count == 0) begin
            $display("tb_adaptive_step_length_controller OK");
        end else begin
            $display("tb_adaptive_step_length_controller NOT OK");
        end
        $finish;
    end

endmodule
